### rtl/core/pkhm_pkg.sv
// pkhm_pkg: shared types and constants for the pair key hash map
// no dependencies; imported by every module of the block

package pkhm_pkg;

    localparam int SLOT_BITS    = 12;
    localparam int SLOT_COUNT   = 1 << SLOT_BITS;
    localparam int TOKEN_BITS   = 20;
    localparam int CFG_W        = 12;
    localparam int CNT_W        = SLOT_BITS + 1;
    localparam int CMP_W        = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    // front stage, queue, item in the probe engine, response register
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;

    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(3072);

    typedef logic [TOKEN_BITS-1:0] token_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t  kind;
        token_t left_token;
        token_t right_token;
        token_t value_id;
    } req_t;

    typedef struct packed {
        status_t status;
        token_t  found_id;
    } rsp_t;

    typedef struct packed {
        req_t  item;
        slot_t start;
    } work_t;

    typedef struct packed {
        logic   valid;
        token_t left_token;
        token_t right_token;
        token_t id;
    } entry_t;

endpackage

### rtl/core/pair_key_hash_map_core.sv
// pair_key_hash_map_core: top level of the pair key hash map
// depends on pkhm_pkg, pkhm_front, pkhm_queue, pkhm_back
//
// Maps a (left_token, right_token) pair to a stored id in an open-addressing
// table of SLOT_COUNT slots with linear probing.
// req channel: one transaction per lookup (kind 0) or insert/update (kind 1).
// rsp channel: exactly one transaction per request, in request order, with
// status (found/updated, miss/new, full) and found_id.
// cfg channel: writes entry_limit, the most keys held before new inserts are
// rejected; cfg_ready is always high, write only while the block is idle.
// After reset the slot memory is swept clear, one slot a cycle, all SLOT_COUNT
// (4096) slots, with req_stall high; entry_limit resets to 3072.
// Each request passes the front register, the queue and the probe engine,
// then the response register raises rsp_valid. The probe engine reads one
// slot per cycle from its single read port until a slot is empty or matches,
// and takes a new request only after the last is answered. A two-entry queue
// between hashing and probing keeps requests flowing while a response waits;
// when rsp_stall is held, the response register holds and requests back up until req_stall rises.

module pair_key_hash_map_core
    import pkhm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp
);

    logic [CFG_W-1:0] limit_reg;
    logic             clearing;
    logic             push_valid;
    logic             push_ready;
    work_t            push_data;
    logic             pop_valid;
    logic             pop_ready;
    work_t            pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    pkhm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (clearing),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pkhm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pkhm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_limit (limit_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .clearing    (clearing),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule

### rtl/core/pkhm_front.sv
// pkhm_front: input register and start slot hash of each request
// depends on pkhm_pkg

module pkhm_front
    import pkhm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  hold,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  push_valid,
    input  logic  push_ready,
    output work_t push_data
);

    // xor fold of the key onto the slot index, left token rotated and xored into the right token first
    function automatic slot_t start_slot(token_t l, token_t r);
        logic [2*TOKEN_BITS-1:0] key;
        slot_t                   h;
        key = {r ^ {l[TOKEN_BITS-8:0], l[TOKEN_BITS-1:TOKEN_BITS-7]}, l};
        h   = '0;
        for (int i = 0; i < 2*TOKEN_BITS; i++)
        begin
            h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ key[i];
        end
        return h;
    endfunction

    logic valid_reg;
    logic valid_next;
    req_t item_reg;
    logic accept;

    assign req_stall  = hold || (valid_reg && !push_ready);
    assign accept     = req_valid && !req_stall;
    assign push_valid = valid_reg;

    always_comb
    begin
        push_data.item  = item_reg;
        push_data.start = start_slot(item_reg.left_token, item_reg.right_token);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

endmodule

### rtl/core/pkhm_queue.sv
// pkhm_queue: short fifo of hashed requests between front and probe engine
// depends on pkhm_pkg

module pkhm_queue
    import pkhm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  work_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output work_t pop_data
);

    work_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/pkhm_back.sv
// pkhm_back: probe engine with the slot memory, key count and response register
// depends on pkhm_pkg

module pkhm_back
    import pkhm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] entry_limit,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  work_t            pop_data,
    output logic             clearing,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_PROBE = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    slot_t            clr_addr_reg;
    slot_t            clr_addr_next;
    slot_t            probe_addr_reg;
    slot_t            probe_addr_next;
    req_t             item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_t             out_data_reg;
    rsp_t             out_data_next;
    entry_t           rd_data_reg;
    entry_t           mem [SLOT_COUNT];

    slot_t            rd_addr;
    slot_t            wr_addr;
    entry_t           wr_data;
    logic             wr_en;
    logic             out_free;
    logic             hit;
    logic             stop;
    logic             full;
    logic [CMP_W-1:0] limit_ext;
    logic [CMP_W-1:0] limit_eff;

    assign pop_ready = (state_reg == S_IDLE);
    assign clearing  = (state_reg == S_CLEAR);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign hit  = rd_data_reg.valid
               && (rd_data_reg.left_token == item_reg.left_token)
               && (rd_data_reg.right_token == item_reg.right_token);
    assign stop = !rd_data_reg.valid || hit;

    // one slot always stays empty so every probe chain ends
    assign limit_ext = CMP_W'(entry_limit);
    assign limit_eff = (limit_ext > CMP_W'(SLOT_COUNT-1)) ? CMP_W'(SLOT_COUNT-1) : limit_ext;
    assign full      = (CMP_W'(count_reg) >= limit_eff);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        probe_addr_next = probe_addr_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_data_next   = out_data_reg;
        rd_addr         = probe_addr_reg;
        wr_addr         = probe_addr_reg;
        wr_data         = rd_data_reg;
        wr_en           = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + slot_t'(1);
                if (clr_addr_reg == slot_t'(SLOT_COUNT-1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = pop_data.start;
                if (pop_valid)
                begin
                    probe_addr_next = pop_data.start;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!stop)
                begin
                    probe_addr_next = probe_addr_reg + slot_t'(1);
                    rd_addr         = probe_addr_reg + slot_t'(1);
                end
                else if (out_free)
                begin
                    state_next             = S_IDLE;
                    out_valid_next         = 1'b1;
                    out_data_next.found_id = '0;
                    if (item_reg.kind == KIND_LOOKUP)
                    begin
                        out_data_next.status = hit ? ST_FOUND : ST_NEW;
                        if (hit)
                        begin
                            out_data_next.found_id = rd_data_reg.id;
                        end
                    end
                    else if (hit)
                    begin
                        wr_en                = 1'b1;
                        wr_data.id           = item_reg.value_id;
                        out_data_next.status = ST_FOUND;
                    end
                    else if (full)
                    begin
                        out_data_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en                = 1'b1;
                        wr_data.valid        = 1'b1;
                        wr_data.left_token   = item_reg.left_token;
                        wr_data.right_token  = item_reg.right_token;
                        wr_data.id           = item_reg.value_id;
                        count_next           = count_reg + CNT_W'(1);
                        out_data_next.status = ST_NEW;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_addr_reg <= probe_addr_next;
        out_data_reg   <= out_data_next;
        if (pop_valid && pop_ready)
        begin
            item_reg <= pop_data.item;
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

### rtl/core/pkhm_checker.sv
// pkhm_checker: port-level checks of the pair key hash map, bound to the top
// depends on pkhm_pkg and pair_key_hash_map_core

module pkhm_checker
    import pkhm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    localparam int INF_W = $clog2(MAX_INFLIGHT + 2);

    logic [INF_W-1:0] inflight_reg;
    logic [INF_W-1:0] inflight_next;
    logic             req_take;
    logic             rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_take && !rsp_take)
        begin
            inflight_next = inflight_reg + INF_W'(1);
        end
        else if (rsp_take && !req_take)
        begin
            inflight_next = inflight_reg - INF_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a response only ever answers an outstanding request
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> inflight_reg != '0)
        else $error("response without outstanding request");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INF_W'(MAX_INFLIGHT))
        else $error("more transactions in flight than the block can hold");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_FOUND |-> rsp.found_id == '0)
        else $error("found_id nonzero on miss or rejected insert");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

endmodule

bind pair_key_hash_map_core pkhm_checker u_checker (.*);

### test/pair_key_hash_map_core_test.sv
// pair_key_hash_map_core_test: self-checking testbench for the pair key hash map
// drives lookups and inserts, predicts each response from a shadow map keyed by the pair
// depends on pkhm_pkg and pair_key_hash_map_core
`timescale 1ns / 100ps

module pair_key_hash_map_core_test;
    import pkhm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp;

    pair_key_hash_map_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = !clk;

    // shadow of the table: pair key -> merged id
    token_t                        pair_ids [logic [2*TOKEN_BITS-1:0]];
    int unsigned                   pair_total = 0;
    logic [CFG_W-1:0]              limit_reg = LIMIT_RESET;

    req_t                          req_backlog [$];
    rsp_t                          due_rsp [$];
    logic [2*TOKEN_BITS-1:0]       known_keys [$];
    int                            items_queued = 0;
    int                            results_seen = 0;
    int                            errors = 0;
    int                            cycle_count = 0;

    logic                          req_took = 1'b0;
    logic                          cfg_took = 1'b0;
    int                            req_gap = 0;
    int                            rsp_hold = 0;
    bit                            req_calm = 1'b0;
    bit                            rsp_calm = 1'b0;

    function automatic rsp_t apply_pair(req_t it);
        rsp_t                    r;
        logic [2*TOKEN_BITS-1:0] key;
        int unsigned             cap;
        key = {it.left_token, it.right_token};
        cap = (limit_reg > SLOT_COUNT - 1) ? SLOT_COUNT - 1 : limit_reg;
        r.found_id = '0;
        if (it.kind == KIND_LOOKUP) begin
            if (pair_ids.exists(key)) begin
                r.status   = ST_FOUND;
                r.found_id = pair_ids[key];
            end
            else begin
                r.status = ST_NEW;
            end
        end
        else if (pair_ids.exists(key)) begin
            pair_ids[key] = it.value_id;
            r.status      = ST_FOUND;
        end
        else if (pair_total >= cap) begin
            r.status = ST_FULL;
        end
        else begin
            pair_ids[key] = it.value_id;
            pair_total++;
            r.status = ST_NEW;
        end
        return r;
    endfunction

    function automatic int idle_len(bit calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic token_t corner_token();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return token_t'(1);
            default: return token_t'($urandom_range(0, 15));
        endcase
    endfunction

    // mostly keys seen before so lookups hit and inserts update, the rest fresh
    function automatic req_t random_pair_req();
        req_t it;
        int   pick;
        pick = $urandom_range(0, 99);
        it.kind = ($urandom_range(0, 1) != 0) ? KIND_INSERT : KIND_LOOKUP;
        if (pick < 55 && known_keys.size() != 0) begin
            {it.left_token, it.right_token} =
                known_keys[$urandom_range(0, known_keys.size() - 1)];
        end
        else begin
            if (pick < 65) begin
                it.left_token  = corner_token();
                it.right_token = corner_token();
            end
            else begin
                it.left_token  = token_t'($urandom);
                it.right_token = token_t'($urandom);
            end
            known_keys.push_back({it.left_token, it.right_token});
        end
        it.value_id = (pick % 4 == 0) ? corner_token() : token_t'($urandom);
        return it;
    endfunction

    task automatic add_item(kind_t k, token_t l, token_t r, token_t v);
        req_t it;
        it.kind        = k;
        it.left_token  = l;
        it.right_token = r;
        it.value_id    = v;
        known_keys.push_back({l, r});
        req_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (results_seen != items_queued)
            @(negedge clk);
    endtask

    task automatic run_random(int count);
        repeat (count) begin
            req_backlog.push_back(random_pair_req());
            items_queued++;
        end
        wait_idle();
    endtask

    task automatic write_limit(int unsigned value);
        wait_idle();
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        do
            @(negedge clk);
        while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_took) begin
            if (req_gap > 0) begin
                req_valid <= 1'b0;
                req_gap--;
            end
            else if (req_backlog.size() != 0) begin
                req       <= req_backlog.pop_front();
                req_valid <= 1'b1;
                req_gap   = idle_len(req_calm);
            end
            else begin
                req_valid <= 1'b0;
            end
            if ($urandom_range(0, 49) == 0)
                req_calm = !req_calm;
        end
    end

    // response back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end
        else if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
        end
        else begin
            rsp_stall <= 1'b0;
            rsp_hold  = idle_len(rsp_calm);
            if ($urandom_range(0, 49) == 0)
                rsp_calm = !rsp_calm;
        end
    end

    // monitor: check responses, predict accepted requests, track config writes
    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            req_took <= 1'b0;
            cfg_took <= 1'b0;
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                if (due_rsp.size() == 0) begin
                    $error("unexpected transaction: status %0d found_id %h",
                           rsp.status, rsp.found_id);
                    errors++;
                end
                else begin
                    want = due_rsp.pop_front();
                    results_seen++;
                    if (rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.found_id !== want.found_id) begin
                        $error("found_id: expected %h, got %h", want.found_id, rsp.found_id);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
                due_rsp.push_back(apply_pair(req));
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            req_took <= req_valid && !req_stall;
            cfg_took <= cfg_valid && cfg_ready;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // empty table, default limit
        add_item(KIND_LOOKUP, '0, '0, '0);
        add_item(KIND_INSERT, '0, '0, '0);
        add_item(KIND_LOOKUP, '0, '0, '1);
        add_item(KIND_INSERT, '0, '0, '1);
        add_item(KIND_LOOKUP, '0, '0, '0);
        add_item(KIND_LOOKUP, '1, '1, '1);
        add_item(KIND_INSERT, '1, '1, 20'hAAAAA);
        add_item(KIND_INSERT, '1, '0, 20'h55555);
        add_item(KIND_INSERT, '0, '1, 20'h12345);
        add_item(KIND_LOOKUP, '1, '0, '0);
        add_item(KIND_LOOKUP, '0, '1, '0);
        add_item(KIND_LOOKUP, '1, '1, '0);
        add_item(KIND_LOOKUP, 20'h5A5A5, 20'hA5A5A, '1);
        wait_idle();

        // zero limit: new keys rejected, updates still go through
        write_limit(0);
        add_item(KIND_INSERT, 20'h00001, 20'h00002, 20'h00003);
        add_item(KIND_INSERT, '0, '0, 20'h00007);
        add_item(KIND_LOOKUP, 20'h00001, 20'h00002, '0);
        add_item(KIND_LOOKUP, '0, '0, '0);
        wait_idle();

        // fill to the limit, then reject, then update at the limit
        write_limit(pair_total + 2);
        add_item(KIND_INSERT, 20'h00010, 20'h00020, 20'h00100);
        add_item(KIND_INSERT, 20'h00011, 20'h00021, 20'h00101);
        add_item(KIND_INSERT, 20'h00012, 20'h00022, 20'h00102);
        add_item(KIND_INSERT, 20'h00010, 20'h00020, 20'hFEDCB);
        add_item(KIND_LOOKUP, 20'h00010, 20'h00020, '0);
        add_item(KIND_LOOKUP, 20'h00012, 20'h00022, '0);
        wait_idle();

        write_limit(SLOT_COUNT - 1);
        run_random(250);
        write_limit(pair_total + $urandom_range(3, 40));
        run_random(100);
        write_limit(1);
        run_random(60);
        write_limit($urandom_range(0, SLOT_COUNT - 1));
        run_random(80);
        write_limit(pair_total + $urandom_range(3, 20));
        run_random(80);
        write_limit(LIMIT_RESET);
        run_random(50);

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/core/pkhm_pkg.sv
rtl/core/pkhm_front.sv
rtl/core/pkhm_queue.sv
rtl/core/pkhm_back.sv
rtl/core/pair_key_hash_map_core.sv
rtl/core/pkhm_checker.sv
test/pair_key_hash_map_core_test.sv
